[rtl/script_token_lexer_core_defines.svh]
// Assertion macros shared by the lexer checker.
`ifndef SCRIPT_TOKEN_LEXER_CORE_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define STL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/stl_pkg.sv]
// Shared types, token codes and fixed-word tables for the script token lexer.
package stl_pkg;

  localparam int NUM_FIXED   = 12;
  localparam int FIXED_CHARS = 13;
  localparam int WORD_VAR    = 0;
  localparam int WORD_RETURN = 1;
  localparam int FIRST_KEYWORD = 2;
  // At most this many characters of one token are sent out
  localparam logic [4:0] EMIT_LIMIT = 5'd31;

  typedef enum logic [3:0] {
    KIND_NUMBER    = 4'd0,
    KIND_VAR       = 4'd1,
    KIND_RETURN    = 4'd2,
    KIND_KEYWORD   = 4'd3,
    KIND_IDENT     = 4'd4,
    KIND_SEMICOLON = 4'd5,
    KIND_EQUALS    = 4'd6,
    KIND_PLUS      = 4'd7,
    KIND_MINUS     = 4'd8,
    KIND_TIMES     = 4'd9,
    KIND_DIVIDE    = 4'd10
  } stl_kind_e;

  // Fixed words, right-justified: first character in the highest used byte
  localparam logic [FIXED_CHARS*8-1:0] FIXED_STR [NUM_FIXED] = '{
    "var", "return", "if", "while", "greater", {"greater", "_equal"},
    "lesser", {"lesser", "_equal"}, "equal", {"end", "_loop"}, "end_if",
    {"not", "_equal"}
  };

  localparam logic [3:0] FIXED_LEN [NUM_FIXED] = '{
    4'd3, 4'd6, 4'd2, 4'd5, 4'd7, 4'd13, 4'd6, 4'd12, 4'd5, 4'd8, 4'd6, 4'd9
  };

  // Character idx of fixed word w; only meaningful for idx below its length
  function automatic logic [7:0] fixed_char(input logic [3:0] w, input logic [3:0] idx);
    logic [FIXED_CHARS*8-1:0] s;
    logic [3:0]               sh;
    s  = FIXED_STR[w];
    sh = FIXED_LEN[w] - idx - 4'd1;
    s  = s >> {sh, 3'b000};
    return s[7:0];
  endfunction

  // One emit job: token text from a store bank and/or an operator after it
  typedef struct packed {
    logic       has_text;
    stl_kind_e  kind;
    logic [4:0] len;
    logic       bank;
    logic       digit_sel;
    logic       has_op;
    stl_kind_e  op_kind;
    logic [7:0] op_char;
  } stl_cmd_t;

  // Back end hands a store bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } stl_release_t;

endpackage

[rtl/script_token_lexer_core.sv]
// Top level of the script token lexer: front end, job queue, text store, back end.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------
//  input    | push / full      | text_byte_i, end_of_text_i
//  result   | empty / pop      | token_kind_o, text_char_o, char_position_o,
//           |                  | token_end_o, run_end_o
//
// The front end takes one byte per cycle while full is low; a byte that ends a token
// queues one job. The back end issues one result per cycle while the result queue has
// room, through the single text-store read port, so a byte with many results keeps it
// busy while the front end fills the other bank. full rises when the job queue is full or
// the text bank to be filled is still being read out; a stalled pop holds the oldest
// result in place. Reset clears all control state at once; there is no clearing pass.
module script_token_lexer_core #(
  parameter int MAX_TOKEN_CHARS = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] token_kind_o,
  output logic [7:0] text_char_o,
  output logic [4:0] char_position_o,
  output logic       token_end_o,
  output logic       run_end_o
);

  localparam int AW = $clog2(MAX_TOKEN_CHARS);

  logic                  fe_cmd_push, q_full, q_valid, be_cmd_pop;
  stl_pkg::stl_cmd_t     fe_cmd, q_cmd;
  stl_pkg::stl_release_t be_release;
  logic                  mem_we;
  logic [AW+1:0]         mem_waddr, mem_raddr;
  logic [7:0]            mem_wdata, mem_rdata;

  stl_front #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS),
    .AW             (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .cmd_push_o   (fe_cmd_push),
    .cmd_o        (fe_cmd),
    .cmd_full_i   (q_full),
    .release_i    (be_release),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata)
  );

  stl_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_cmd_push),
    .cmd_i  (fe_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .cmd_o  (q_cmd),
    .pop_i  (be_cmd_pop)
  );

  stl_text_mem #(
    .AW(AW)
  ) u_text_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  stl_back #(
    .AW(AW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .cmd_pop_o      (be_cmd_pop),
    .release_o      (be_release),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .empty          (empty),
    .pop            (pop),
    .token_kind_o   (token_kind_o),
    .text_char_o    (text_char_o),
    .char_position_o(char_position_o),
    .token_end_o    (token_end_o),
    .run_end_o      (run_end_o)
  );

endmodule

[rtl/stl_front.sv]
// Front end: takes source bytes, collects word and digit text, classifies tokens.
module stl_front #(
  parameter int MAX_TOKEN_CHARS = 31,
  parameter int AW = $clog2(MAX_TOKEN_CHARS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  output logic                  cmd_push_o,
  output stl_pkg::stl_cmd_t     cmd_o,
  input  logic                  cmd_full_i,
  input  stl_pkg::stl_release_t release_i,
  output logic                  mem_we_o,
  output logic [AW+1:0]         mem_waddr_o,
  output logic [7:0]            mem_wdata_o
);

  localparam int LW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam logic [6:0] MAX7 = 7'(MAX_TOKEN_CHARS);

  logic [LW-1:0]                 word_len_q, word_len_d;
  logic [LW-1:0]                 digit_len_q, digit_len_d;
  logic                          in_digits_q, in_digits_d;
  logic [stl_pkg::NUM_FIXED-1:0] cand_q, cand_d;
  logic                          bank_q;
  logic [1:0]                    bank_busy_q;

  logic       accept;
  logic       is_letter, is_digit, take_letter, take_digit, ends;
  logic [6:0] wlen7, dlen7;
  logic       we;
  logic [AW+1:0] waddr;

  logic [6:0]                    src_wlen7, src_dlen7;
  logic [stl_pkg::NUM_FIXED-1:0] src_cand, exact;
  logic                          src_space, do_flush, has_text, has_op, any_kw;
  logic [6:0]                    src_len7;
  stl_pkg::stl_kind_e            tok_kind, op_kind;
  logic                          op_valid;
  logic [4:0]                    op_dec;

  // Operator byte decode
  function automatic logic [4:0] decode_op(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h3B:   r = {1'b1, stl_pkg::KIND_SEMICOLON};  // ;
      8'h3D:   r = {1'b1, stl_pkg::KIND_EQUALS};     // =
      8'h2B:   r = {1'b1, stl_pkg::KIND_PLUS};       // +
      8'h2D:   r = {1'b1, stl_pkg::KIND_MINUS};      // -
      8'h2A:   r = {1'b1, stl_pkg::KIND_TIMES};      // *
      8'h2F:   r = {1'b1, stl_pkg::KIND_DIVIDE};     // /
      default: r = {1'b0, stl_pkg::KIND_NUMBER};
    endcase
    return r;
  endfunction

  assign full   = cmd_full_i | bank_busy_q[bank_q];
  assign accept = push & ~full;

  assign is_letter = (text_byte_i >= 8'h41 && text_byte_i <= 8'h5A) ||
                     (text_byte_i >= 8'h61 && text_byte_i <= 8'h7A) ||
                     (text_byte_i == 8'h5F);
  assign is_digit    = text_byte_i >= 8'h30 && text_byte_i <= 8'h39;
  assign take_letter = is_letter & ~in_digits_q;
  assign take_digit  = is_digit;
  assign ends        = ~take_letter & ~take_digit;

  assign wlen7 = 7'(word_len_q);
  assign dlen7 = 7'(digit_len_q);

  // Text collection and keyword prefix tracking
  always_comb begin
    word_len_d  = word_len_q;
    digit_len_d = digit_len_q;
    in_digits_d = in_digits_q;
    cand_d      = cand_q;
    we          = 1'b0;
    waddr       = {bank_q, 1'b0, word_len_q[AW-1:0]};
    if (take_letter) begin
      if (wlen7 >= MAX7) begin
        cand_d = '0;
      end else begin
        for (int w = 0; w < stl_pkg::NUM_FIXED; w++) begin
          if (wlen7 >= 7'(stl_pkg::FIXED_LEN[w]) ||
              stl_pkg::fixed_char(4'(w), wlen7[3:0]) != text_byte_i) begin
            cand_d[w] = 1'b0;
          end
        end
        we         = 1'b1;
        word_len_d = word_len_q + LW'(1);
      end
    end else if (take_digit) begin
      in_digits_d = 1'b1;
      waddr       = {bank_q, 1'b1, digit_len_q[AW-1:0]};
      if (dlen7 < MAX7) begin
        we          = 1'b1;
        digit_len_d = digit_len_q + LW'(1);
      end
    end
  end

  // Token classification on the state that the flush sees
  always_comb begin
    src_wlen7 = ends ? wlen7 : 7'(word_len_d);
    src_dlen7 = ends ? dlen7 : 7'(digit_len_d);
    src_cand  = ends ? cand_q : cand_d;
    src_space = ends && (text_byte_i == 8'h20);
    do_flush  = ends | end_of_text_i;
    has_text  = do_flush && (src_dlen7 != 7'd0 || src_wlen7 != 7'd0);
    op_dec    = decode_op(text_byte_i);
    op_valid  = op_dec[4];
    op_kind   = stl_pkg::stl_kind_e'(op_dec[3:0]);
    has_op    = ends & ~is_letter & op_valid;
    for (int w = 0; w < stl_pkg::NUM_FIXED; w++) begin
      exact[w] = src_cand[w] && (src_wlen7 == 7'(stl_pkg::FIXED_LEN[w]));
    end
    any_kw = |exact[stl_pkg::NUM_FIXED-1:stl_pkg::FIRST_KEYWORD];
    if (src_dlen7 != 7'd0) begin
      tok_kind = stl_pkg::KIND_NUMBER;
      src_len7 = src_dlen7;
    end else begin
      src_len7 = src_wlen7;
      if (src_space && exact[stl_pkg::WORD_VAR]) begin
        tok_kind = stl_pkg::KIND_VAR;
      end else if (src_space && exact[stl_pkg::WORD_RETURN]) begin
        tok_kind = stl_pkg::KIND_RETURN;
      end else if (any_kw) begin
        tok_kind = stl_pkg::KIND_KEYWORD;
      end else begin
        tok_kind = stl_pkg::KIND_IDENT;
      end
    end
  end

  assign cmd_o.has_text  = has_text;
  assign cmd_o.kind      = tok_kind;
  assign cmd_o.len       = (src_len7 > 7'(stl_pkg::EMIT_LIMIT)) ? stl_pkg::EMIT_LIMIT
                                                                : src_len7[4:0];
  assign cmd_o.bank      = bank_q;
  assign cmd_o.digit_sel = src_dlen7 != 7'd0;
  assign cmd_o.has_op    = has_op;
  assign cmd_o.op_kind   = op_kind;
  assign cmd_o.op_char   = text_byte_i;
  assign cmd_push_o      = accept & (has_text | has_op);

  assign mem_we_o    = accept & we;
  assign mem_waddr_o = waddr;
  assign mem_wdata_o = text_byte_i;

  // Token state, current bank and bank ownership
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_len_q  <= '0;
      digit_len_q <= '0;
      in_digits_q <= 1'b0;
      cand_q      <= '1;
      bank_q      <= 1'b0;
      bank_busy_q <= '0;
    end else begin
      if (accept) begin
        if (do_flush) begin
          word_len_q  <= '0;
          digit_len_q <= '0;
          in_digits_q <= 1'b0;
          cand_q      <= '1;
          if (has_text) begin
            bank_q <= ~bank_q;
          end
        end else begin
          word_len_q  <= word_len_d;
          digit_len_q <= digit_len_d;
          in_digits_q <= in_digits_d;
          cand_q      <= cand_d;
        end
      end
      if (release_i.valid) begin
        bank_busy_q[release_i.bank] <= 1'b0;
      end
      if (cmd_push_o && has_text) begin
        bank_busy_q[bank_q] <= 1'b1;
      end
    end
  end

endmodule

[rtl/stl_cmd_fifo.sv]
// Two-entry queue of emit jobs between the front and back ends.
module stl_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stl_pkg::stl_cmd_t cmd_i,
  output logic              full_o,
  output logic              valid_o,
  output stl_pkg::stl_cmd_t cmd_o,
  input  logic              pop_i
);

  stl_pkg::stl_cmd_t entry_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[rtl/stl_text_mem.sv]
// Token text store: two banks, each with a word area and a digit area.
module stl_text_mem #(
  parameter int AW = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW+1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW+1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  localparam int DEPTH = 1 << (AW + 2);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/stl_back.sv]
// Back end: walks emit jobs, reads token text and queues result transactions.
module stl_back #(
  parameter int AW = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  stl_pkg::stl_cmd_t     cmd_i,
  output logic                  cmd_pop_o,
  output stl_pkg::stl_release_t release_o,
  output logic [AW+1:0]         mem_raddr_o,
  input  logic [7:0]            mem_rdata_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [3:0]            token_kind_o,
  output logic [7:0]            text_char_o,
  output logic [4:0]            char_position_o,
  output logic                  token_end_o,
  output logic                  run_end_o
);

  typedef struct packed {
    stl_pkg::stl_kind_e kind;
    logic [7:0]         ch;
    logic [4:0]         pos;
    logic               tok_end;
    logic               run_end;
  } out_t;

  logic [4:0]         pos_q;
  logic               op_phase_q;
  logic               s2_valid_q, s2_from_mem_q;
  stl_pkg::stl_kind_e s2_kind_q;
  logic [4:0]         s2_pos_q;
  logic               s2_tend_q, s2_rend_q;
  logic [7:0]         s2_char_q;

  out_t       ofifo_q [4];
  logic [1:0] owr_q, ord_q;
  logic [2:0] ocount_q;

  logic               credit, issue, text_phase, last_text;
  stl_pkg::stl_kind_e slot_kind;
  logic [4:0]         slot_pos;
  logic               slot_tend, slot_rend;
  out_t               wr_item;
  logic               do_pop;

  // One slot per cycle while the output queue has room for it
  assign credit     = (ocount_q + 3'(s2_valid_q)) < 3'd4;
  assign issue      = cmd_valid_i & credit;
  assign text_phase = cmd_i.has_text & ~op_phase_q;
  assign last_text  = pos_q == (cmd_i.len - 5'd1);

  always_comb begin
    if (text_phase) begin
      slot_kind = cmd_i.kind;
      slot_pos  = pos_q;
      slot_tend = last_text;
      slot_rend = last_text & ~cmd_i.has_op;
    end else begin
      slot_kind = cmd_i.op_kind;
      slot_pos  = 5'd0;
      slot_tend = 1'b1;
      slot_rend = 1'b1;
    end
  end

  assign cmd_pop_o       = issue & (~text_phase | (last_text & ~cmd_i.has_op));
  assign release_o.valid = issue & text_phase & last_text;
  assign release_o.bank  = cmd_i.bank;
  assign mem_raddr_o     = {cmd_i.bank, cmd_i.digit_sel, AW'(pos_q)};

  // Job walk: text characters, then the operator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      op_phase_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= issue;
      if (issue) begin
        if (text_phase && !last_text) begin
          pos_q <= pos_q + 5'd1;
        end else if (text_phase && cmd_i.has_op) begin
          pos_q      <= '0;
          op_phase_q <= 1'b1;
        end else begin
          pos_q      <= '0;
          op_phase_q <= 1'b0;
        end
      end
    end
  end

  // Slot fields wait here for the memory read data
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_from_mem_q <= text_phase;
      s2_kind_q     <= slot_kind;
      s2_pos_q      <= slot_pos;
      s2_tend_q     <= slot_tend;
      s2_rend_q     <= slot_rend;
      s2_char_q     <= cmd_i.op_char;
    end
  end

  assign wr_item.kind    = s2_kind_q;
  assign wr_item.ch      = s2_from_mem_q ? mem_rdata_i : s2_char_q;
  assign wr_item.pos     = s2_pos_q;
  assign wr_item.tok_end = s2_tend_q;
  assign wr_item.run_end = s2_rend_q;

  assign empty  = ocount_q == 3'd0;
  assign do_pop = pop & ~empty;

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      ofifo_q[owr_q] <= wr_item;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q    <= '0;
      ord_q    <= '0;
      ocount_q <= '0;
    end else begin
      if (s2_valid_q) begin
        owr_q <= owr_q + 2'd1;
      end
      if (do_pop) begin
        ord_q <= ord_q + 2'd1;
      end
      ocount_q <= ocount_q + 3'(s2_valid_q) - 3'(do_pop);
    end
  end

  assign token_kind_o    = ofifo_q[ord_q].kind;
  assign text_char_o     = ofifo_q[ord_q].ch;
  assign char_position_o = ofifo_q[ord_q].pos;
  assign token_end_o     = ofifo_q[ord_q].tok_end;
  assign run_end_o       = ofifo_q[ord_q].run_end;

endmodule

[rtl/stl_checker.sv]
// Port-level checks on the lexer result channel, bound to the top level.
`include "script_token_lexer_core_defines.svh"

module stl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [3:0] token_kind_o,
  input logic [7:0] text_char_o,
  input logic [4:0] char_position_o,
  input logic       token_end_o,
  input logic       run_end_o
);

  logic        res_valid;
  logic [18:0] res_bus;
  logic        kind_ok, pos_ok, is_op, op_ok;

  // Views of the result transaction
  assign res_valid = !empty;
  assign res_bus   = {token_kind_o, text_char_o, char_position_o, token_end_o, run_end_o};
  assign kind_ok   = token_kind_o <= stl_pkg::KIND_DIVIDE;
  assign pos_ok    = char_position_o < stl_pkg::EMIT_LIMIT;
  assign is_op     = token_kind_o >= stl_pkg::KIND_SEMICOLON;
  assign op_ok     = token_end_o && run_end_o && (char_position_o == 5'd0);

  // Only defined token codes and in-range positions leave the block
  `STL_ASSERT_IMPL(a_kind_range, res_valid, kind_ok && pos_ok, "kind or position out of range")

  // An operator is a one-character token that closes its byte's run
  `STL_ASSERT_IMPL(a_op_single, res_valid && is_op, op_ok, "operator result malformed")

  // A run always closes on a token boundary
  `STL_ASSERT_IMPL(a_run_on_token, res_valid && run_end_o, token_end_o, "run end inside a token")

  // A waiting result holds until it is taken
  `STL_ASSERT_NEXT(a_hold, res_valid && !pop, res_valid && $stable(res_bus), "result changed")

endmodule

bind script_token_lexer_core stl_checker u_stl_checker (.*);

[tb/sv/script_token_lexer_checker.sv]
// Result checker for the script token lexer: predicts token characters and compares them.
`timescale 1ns / 100ps
module script_token_lexer_checker #(
  parameter int MAX_TOKEN_CHARS = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       empty,
  input  logic       pop,
  input  logic [3:0] token_kind_o,
  input  logic [7:0] text_char_o,
  input  logic [4:0] char_position_o,
  input  logic       token_end_o,
  input  logic       run_end_o,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  localparam int STORE_SLOTS = 64;
  localparam int STORE_LIMIT = (MAX_TOKEN_CHARS < STORE_SLOTS) ? MAX_TOKEN_CHARS : STORE_SLOTS;
  localparam int EMIT_MAX    = int'(stl_pkg::EMIT_LIMIT);
  localparam int REPORT_MAX  = 10;

  // One expected result: a single character of a token
  typedef struct packed {
    stl_pkg::stl_kind_e kind;
    logic [7:0]         ch;
    logic [4:0]         pos;
    logic               tok_end;
    logic               run_last;
  } token_char_t;

  token_char_t pending_chars[$];  // expected results, oldest first
  token_char_t byte_chars[$];     // results caused by the byte being lexed

  // Lexer state
  logic [7:0]  word_buf [STORE_SLOTS];
  logic [7:0]  num_buf  [STORE_SLOTS];
  int          word_cnt;
  int          digit_cnt;
  bit          in_num;
  logic [11:0] cand;

  int fails;
  int checked;

  function automatic string fixed_word(int w);
    case (w)
      0:       return "var";
      1:       return "return";
      2:       return "if";
      3:       return "while";
      4:       return "greater";
      5:       return $sformatf("%s%s", "greater", "_equal");
      6:       return "lesser";
      7:       return $sformatf("%s%s", "lesser", "_equal");
      8:       return "equal";
      9:       return $sformatf("%s%s", "end", "_loop");
      10:      return "end_if";
      default: return $sformatf("%s%s", "not", "_equal");
    endcase
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit op_kind(logic [7:0] c, output stl_pkg::stl_kind_e k);
    k = stl_pkg::KIND_SEMICOLON;
    case (c)
      ";":     k = stl_pkg::KIND_SEMICOLON;
      "=":     k = stl_pkg::KIND_EQUALS;
      "+":     k = stl_pkg::KIND_PLUS;
      "-":     k = stl_pkg::KIND_MINUS;
      "*":     k = stl_pkg::KIND_TIMES;
      "/":     k = stl_pkg::KIND_DIVIDE;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void clear_token();
    word_cnt  = 0;
    digit_cnt = 0;
    in_num    = 1'b0;
    cand      = '1;
  endfunction

  // Narrow the fixed-word candidates; an overlong word matches nothing
  function automatic void add_letter(logic [7:0] c);
    string s;
    if (word_cnt >= STORE_LIMIT) begin
      cand = '0;
      return;
    end
    for (int w = 0; w < stl_pkg::NUM_FIXED; w++) begin
      s = fixed_word(w);
      if (word_cnt >= s.len() || s[word_cnt] != c) cand[w] = 1'b0;
    end
    word_buf[word_cnt] = c;
    word_cnt++;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    if (digit_cnt >= STORE_LIMIT) return;
    num_buf[digit_cnt] = c;
    digit_cnt++;
  endfunction

  function automatic bit exact_word(int w);
    string s;
    s = fixed_word(w);
    return cand[w] && word_cnt == s.len();
  endfunction

  function automatic void add_char(stl_pkg::stl_kind_e k, logic [7:0] c, int pos, bit last);
    token_char_t t;
    t.kind     = k;
    t.ch       = c;
    t.pos      = 5'(pos);
    t.tok_end  = last;
    t.run_last = 1'b0;
    byte_chars.push_back(t);
  endfunction

  function automatic void emit_text(stl_pkg::stl_kind_e k, bit from_digits, int len);
    int n;
    n = (len < EMIT_MAX) ? len : EMIT_MAX;
    for (int i = 0; i < n; i++)
      add_char(k, from_digits ? num_buf[i] : word_buf[i], i, i == n - 1);
  endfunction

  // Emit the pending number or word; a number wins and the word is dropped
  function automatic void flush_token(bit space_next);
    stl_pkg::stl_kind_e k;
    if (digit_cnt > 0) begin
      emit_text(stl_pkg::KIND_NUMBER, 1'b1, digit_cnt);
      return;
    end
    if (word_cnt == 0) return;
    if (space_next && exact_word(stl_pkg::WORD_VAR)) k = stl_pkg::KIND_VAR;
    else if (space_next && exact_word(stl_pkg::WORD_RETURN)) k = stl_pkg::KIND_RETURN;
    else begin
      k = stl_pkg::KIND_IDENT;
      for (int w = stl_pkg::FIRST_KEYWORD; w < stl_pkg::NUM_FIXED; w++)
        if (exact_word(w)) k = stl_pkg::KIND_KEYWORD;
    end
    emit_text(k, 1'b0, word_cnt);
  endfunction

  // Lex one accepted byte and queue the characters it produces
  function automatic void lex_byte(logic [7:0] c, logic eot);
    stl_pkg::stl_kind_e k;
    token_char_t        t;
    byte_chars.delete();
    if (is_letter(c) && !in_num) add_letter(c);
    else if (is_digit(c)) begin
      in_num = 1'b1;
      add_digit(c);
    end else begin
      flush_token(c == " ");
      // a letter that ends a number is dropped
      if (!is_letter(c) && op_kind(c, k)) add_char(k, c, 0, 1'b1);
      clear_token();
    end
    if (eot) begin
      flush_token(1'b0);
      clear_token();
    end
    for (int i = 0; i < byte_chars.size(); i++) begin
      t = byte_chars[i];
      t.run_last = (i == byte_chars.size() - 1);
      pending_chars.push_back(t);
    end
  endfunction

  // Compare one popped result with the oldest expected character
  function automatic void check_result();
    token_char_t t;
    checked++;
    if (pending_chars.size() == 0) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("%0t: unexpected result kind=%0d char=%02h pos=%0d end=%0b run_end=%0b",
                 $time, token_kind_o, text_char_o, char_position_o, token_end_o, run_end_o);
      return;
    end
    t = pending_chars.pop_front();
    if (token_kind_o !== t.kind || text_char_o !== t.ch || char_position_o !== t.pos ||
        token_end_o !== t.tok_end || run_end_o !== t.run_last) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("%0t: result error exp kind=%0d char=%02h pos=%0d end=%0b run_end=%0b, %s",
                 $time, t.kind, t.ch, t.pos, t.tok_end, t.run_last,
                 $sformatf("got kind=%0d char=%02h pos=%0d end=%0b run_end=%0b",
                           token_kind_o, text_char_o, char_position_o, token_end_o,
                           run_end_o));
    end
  endfunction

  // Watch both channels; results are compared before a new byte is lexed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_token();
      pending_chars.delete();
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (pop && !empty) check_result();
      if (push && !full) lex_byte(text_byte_i, end_of_text_i);
      fail_count_o <= fails;
      pending_o    <= pending_chars.size();
      checked_o    <= checked;
    end
  end

endmodule

[tb/sv/script_token_lexer_core_tb.sv]
// Testbench top for the script token lexer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps
module script_token_lexer_core_tb;

  localparam int RAND_ITEMS = 130;
  localparam int RX_HOLD    = 300;
  localparam int DRAIN_TAIL = 16;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } src_byte_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic [7:0] text_byte_i   = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       pop           = 1'b0;
  logic       full;
  logic       empty;
  logic [3:0] token_kind_o;
  logic [7:0] text_char_o;
  logic [4:0] char_position_o;
  logic       token_end_o;
  logic       run_end_o;

  int fail_count;
  int pending;
  int checked;
  int hold_req   = 0;
  int bytes_sent = 0;

  src_byte_t src_q[$];  // source text waiting to be sent

  script_token_lexer_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .empty          (empty),
    .pop            (pop),
    .token_kind_o   (token_kind_o),
    .text_char_o    (text_char_o),
    .char_position_o(char_position_o),
    .token_end_o    (token_end_o),
    .run_end_o      (run_end_o)
  );

  script_token_lexer_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .empty          (empty),
    .pop            (pop),
    .token_kind_o   (token_kind_o),
    .text_char_o    (text_char_o),
    .char_position_o(char_position_o),
    .token_end_o    (token_end_o),
    .run_end_o      (run_end_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic string fixed_word(int w);
    case (w)
      0:       return "var";
      1:       return "return";
      2:       return "if";
      3:       return "while";
      4:       return "greater";
      5:       return $sformatf("%s%s", "greater", "_equal");
      6:       return "lesser";
      7:       return $sformatf("%s%s", "lesser", "_equal");
      8:       return "equal";
      9:       return $sformatf("%s%s", "end", "_loop");
      10:      return "end_if";
      default: return $sformatf("%s%s", "not", "_equal");
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 5))
      0:       return ";";
      1:       return "=";
      2:       return "+";
      3:       return "-";
      4:       return "*";
      default: return "/";
    endcase
  endfunction

  function automatic void push_raw(logic [7:0] b, logic e);
    src_byte_t it;
    it.b = b;
    it.e = e;
    src_q.push_back(it);
  endfunction

  // Random source byte; now and then it closes the buffer
  function automatic void push_rand(logic [7:0] b);
    push_raw(b, $urandom_range(0, 24) == 0);
  endfunction

  function automatic void push_str(string s, logic eot_last);
    for (int i = 0; i < s.len(); i++) push_raw(s[i], eot_last && i == s.len() - 1);
  endfunction

  function automatic void add_letters(int n);
    repeat (n) push_rand(rand_letter());
  endfunction

  function automatic void add_digits(int n);
    repeat (n) push_rand(rand_digit());
  endfunction

  // Byte after a word or number: space, operator, letter, nothing or noise
  function automatic void add_ending();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) push_rand(" ");
    else if (r < 55) push_rand(rand_op());
    else if (r < 70) push_rand(rand_letter());
    else if (r < 85) return;
    else push_rand(8'($urandom_range(0, 255)));
  endfunction

  // One random token, mostly well formed
  function automatic void add_token();
    int    r;
    string s;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      s = fixed_word($urandom_range(0, 11));
      for (int i = 0; i < s.len(); i++) push_rand(s[i]);
      add_ending();
    end else if (r < 38) begin
      add_letters($urandom_range(1, 8));
      add_ending();
    end else if (r < 52) begin
      if ($urandom_range(0, 2) == 0) add_letters($urandom_range(1, 3));
      add_digits($urandom_range(1, 6));
      add_ending();
    end else if (r < 66) push_rand(rand_op());
    else if (r < 76) push_rand(" ");
    else if (r < 88) push_rand(8'($urandom_range(0, 255)));
    else if (r < 94) begin
      add_letters($urandom_range(30, 36));
      add_ending();
    end else begin
      add_digits($urandom_range(30, 34));
      add_ending();
    end
  endfunction

  // Offer one byte and hold it until the block takes it
  task automatic send_byte(src_byte_t it);
    push          <= 1'b1;
    text_byte_i   <= it.b;
    end_of_text_i <= it.e;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Stop sending until every expected result has arrived
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic send_queue(int hold_at, int pause_at);
    int gap;
    int burst;
    burst = 0;
    for (int i = 0; i < src_q.size(); i++) begin
      if (i == hold_at) hold_req <= hold_req + 1;
      if (i == pause_at) wait_drained();
      if (burst > 0) begin
        burst--;
        gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        burst = $urandom_range(20, 60);
        gap   = 0;
      end else gap = pick_gap();
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      send_byte(src_q[i]);
    end
  endtask

  // Result side: random stalls, bursts, and one long hold-off on request
  initial begin : rx_drive
    int stall;
    int burst;
    int seen_hold;
    stall     = 0;
    burst     = 0;
    seen_hold = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != seen_hold) begin
        seen_hold = hold_req;
        stall     = RX_HOLD;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (burst > 0) burst--;
        else if ($urandom_range(0, 19) == 0) burst = $urandom_range(30, 80);
        else stall = pick_gap();
      end
    end
  end

  // Ends the run when no transaction happens for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle = 0;
      else idle++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus and verdict
  initial begin : tx_drive
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: var, keyword, dropped letter after digits, operators, byte extremes,
    // end-of-text flush, return followed by space
    push_str("var ", 1'b0);
    push_str("if=", 1'b0);
    push_str("ab12c", 1'b0);
    push_str("+-*/", 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'hFF, 1'b0);
    push_str("x", 1'b1);
    push_str("return ", 1'b0);
    send_queue(-1, -1);
    wait_drained();

    // Random: start with overlong tokens so a byte yields the most results
    src_q.delete();
    push_raw(" ", 1'b0);
    for (int i = 0; i < 34; i++) push_raw(rand_letter(), 1'b0);
    push_raw("+", 1'b0);
    for (int i = 0; i < 33; i++) push_raw(rand_digit(), 1'b0);
    push_raw(";", 1'b0);
    while (src_q.size() < RAND_ITEMS) add_token();
    send_queue(4, src_q.size() / 2);
    wait_drained();

    $display("covered %0d source bytes and %0d token characters, incl. overlong tokens,",
             bytes_sent, checked);
    $display("a long result hold-off with input backpressure and drain pauses");
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
